### hdl/utf8ls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8ls_pkg: shared definitions of the UTF-8 lossy sanitizer
// Byte class masks, result queue sizing and the queued result type.
// ----------------------------------------------------------------------------
package utf8ls_pkg;

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] MASK_LEAD2  = 8'hE0;
	localparam logic [7:0] CODE_LEAD2  = 8'hC0;
	localparam logic [7:0] MASK_LEAD3  = 8'hF0;
	localparam logic [7:0] CODE_LEAD3  = 8'hE0;
	localparam logic [7:0] MASK_LEAD4  = 8'hF8;
	localparam logic [7:0] CODE_LEAD4  = 8'hF0;
	localparam logic [1:0] CONT_TAG    = 2'b10;

	localparam logic [6:0] REPL_RESET  = 7'd63;

	// most results one byte can cause, and the depth of the result queue
	localparam int MAX_RES = 4;
	localparam int QDEPTH  = 8;
	localparam int CNT_W   = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_done;
	} res_t;

endpackage

### hdl/utf8_lossy_sanitizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_lossy_sanitizer_core: streaming UTF-8 check with byte replacement
// Buffers open multi-byte sequences, passes complete ones through and
// replaces broken, stray or truncated bytes by the replacement byte.
// ----------------------------------------------------------------------------
// Throughput: one input byte per cycle while the result queue has room for
// four more results; results leave one per cycle while out_stall is low, and
// the several results of one byte are absorbed by the eight-entry result queue.
// Reset: arst_n clears the sequence state and empties the queue; the
// replacement byte returns to '?'. Buffered sequence bytes are not cleared.
module utf8_lossy_sanitizer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [6:0] wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       string_done
);

	localparam int QD = utf8ls_pkg::QDEPTH;
	localparam int CW = utf8ls_pkg::CNT_W;

	logic [6:0] repl_q;
	logic [7:0] pend_q [0:2];
	logic [1:0] pcnt_q;
	logic [2:0] slen_q;

	utf8ls_pkg::res_t q_q    [0:QD-1];
	utf8ls_pkg::res_t q_next [0:QD-1];
	utf8ls_pkg::res_t shft   [0:QD-1];
	logic [CW-1:0]    cnt_q;

	logic       in_acc, pop;
	logic [7:0] rep;
	logic       open_seq, is_cont, complete;
	logic [7:0] emit [0:3];
	logic [2:0] n_emit;
	logic [1:0] pcnt_d;
	logic [2:0] slen_d;
	logic       pend_wr;
	logic [1:0] pend_idx;
	logic [1:0] k_rep;
	logic [7:0] fbyte;
	logic       has_f;
	logic [2:0] flen;
	logic [1:0] fpcnt;
	logic [2:0] fslen;
	logic       fwr;
	logic [CW-1:0] cnt_ap;
	logic [CW:0]   cnt_end;
	logic [CW-1:0] slot;

	assign rep       = {1'b0, repl_q};
	assign in_stall  = cnt_q > CW'(QD - utf8ls_pkg::MAX_RES);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && !out_stall;
	assign out_byte    = q_q[0].out_byte;
	assign run_last    = q_q[0].run_last;
	assign string_done = q_q[0].string_done;

	assign open_seq = (slen_q != 3'd0) && (pcnt_q != 2'd0);
	assign is_cont  = data_byte[7:6] == utf8ls_pkg::CONT_TAG;
	assign complete = ({1'b0, pcnt_q} + 3'd1) >= slen_q;

	// classify the byte as if it opened a fresh item
	always_comb begin
		flen  = 3'd0;
		fbyte = data_byte;
		has_f = 1'b1;
		fpcnt = 2'd0;
		fslen = 3'd0;
		fwr   = 1'b0;
		priority if ((data_byte & utf8ls_pkg::MASK_LEAD2) == utf8ls_pkg::CODE_LEAD2) begin
			flen = 3'd2;
		end else if ((data_byte & utf8ls_pkg::MASK_LEAD3) == utf8ls_pkg::CODE_LEAD3) begin
			flen = 3'd3;
		end else if ((data_byte & utf8ls_pkg::MASK_LEAD4) == utf8ls_pkg::CODE_LEAD4) begin
			flen = 3'd4;
		end else begin
			flen = 3'd0;
		end
		if (data_byte >= utf8ls_pkg::ASCII_LIMIT) begin
			if (flen == 3'd0) begin
				fbyte = rep;
			end else begin
				fwr = 1'b1;
				if (end_of_string) begin
					fbyte = rep;
				end else begin
					has_f = 1'b0;
					fpcnt = 2'd1;
					fslen = flen;
				end
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			emit[j] = rep;
		end
		n_emit   = 3'd0;
		pcnt_d   = 2'd0;
		slen_d   = 3'd0;
		pend_wr  = 1'b0;
		pend_idx = 2'd0;
		k_rep    = 2'd0;
		if (open_seq && is_cont && complete) begin
			for (int j = 0; j < 3; j++) begin
				emit[j] = (2'(j) < pcnt_q) ? pend_q[j] : data_byte;
			end
			emit[3] = data_byte;
			n_emit  = {1'b0, pcnt_q} + 3'd1;
		end else if (open_seq && is_cont) begin
			pend_wr  = 1'b1;
			pend_idx = pcnt_q;
			if (end_of_string) begin
				n_emit = {1'b0, pcnt_q} + 3'd1;
			end else begin
				pcnt_d = pcnt_q + 2'd1;
				slen_d = slen_q;
			end
		end else begin
			// flush the broken sequence, then handle the byte as fresh
			k_rep = open_seq ? pcnt_q : 2'd0;
			for (int j = 0; j < 4; j++) begin
				emit[j] = (3'(j) < {1'b0, k_rep}) ? rep : fbyte;
			end
			n_emit   = {1'b0, k_rep} + {2'b00, has_f};
			pcnt_d   = fpcnt;
			slen_d   = fslen;
			pend_wr  = fwr;
			pend_idx = 2'd0;
		end
	end

	// result queue: shift out at the head, append after the survivors
	assign cnt_ap  = cnt_q - CW'(pop);
	assign cnt_end = {1'b0, cnt_ap} + (CW + 1)'(in_acc ? n_emit : 3'd0);

	always_comb begin
		for (int i = 0; i < QD - 1; i++) begin
			shft[i] = pop ? q_q[i+1] : q_q[i];
		end
		shft[QD-1] = q_q[QD-1];
		slot = '0;
		for (int i = 0; i < QD; i++) begin
			q_next[i] = shft[i];
			if ((CW'(i) >= cnt_ap) && ((CW + 1)'(i) < cnt_end)) begin
				slot = CW'(i) - cnt_ap;
				q_next[i].out_byte    = emit[slot[1:0]];
				q_next[i].run_last    = (CW + 1)'(i) == (cnt_end - (CW + 1)'(1));
				q_next[i].string_done = ((CW + 1)'(i) == (cnt_end - (CW + 1)'(1)))
					&& end_of_string;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= utf8ls_pkg::REPL_RESET;
			pcnt_q <= 2'd0;
			slen_q <= 3'd0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				repl_q <= wr_data;
			end
			if (in_acc) begin
				pcnt_q <= pcnt_d;
				slen_q <= slen_d;
			end
			cnt_q <= cnt_end[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && pend_wr) begin
			pend_q[pend_idx] <= data_byte;
		end
		for (int i = 0; i < QD; i++) begin
			q_q[i] <= q_next[i];
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QD))
		else $error("result queue overfilled");

	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> cnt_q <= CW'(QD - utf8ls_pkg::MAX_RES))
		else $error("request taken without room for its results");

	a_seq_state: assert property (@(posedge clk) disable iff (!arst_n)
		((slen_q == 3'd0) == (pcnt_q == 2'd0)) && ({1'b0, pcnt_q} <= slen_q))
		else $error("sequence length and pending count disagree");

	a_eos_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && end_of_string) |=> cnt_q != '0)
		else $error("end of string left no result");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && string_done) |-> run_last)
		else $error("string end flagged on a result that is not the last");

endmodule
